// ----- design/fix_message_framer_assert.svh -----
// Assertion macros used by the framer's checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIX_MESSAGE_FRAMER_ASSERT_SVH
`define FIX_MESSAGE_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fix_message_framer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fix_message_framer assertion failed");

`endif

// ----- design/fmf_pkg.sv -----
// Shared types and constants of the FIX message framer.
// No dependencies; every design module refers to it by scoped names.
package fmf_pkg;

  localparam int DATA_W           = 8;
  localparam int TAG_BYTES        = 8;
  localparam int TAG_IDX_W        = $clog2(TAG_BYTES);
  localparam int TAG_LEN_W        = 4;
  localparam int ML_W             = 20;
  localparam int BL_W             = 16;
  localparam int REM_W            = BL_W + 1;
  localparam int DIGIT_CNT_W      = 3;
  localparam int OUT_TDATA_W      = 40;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_ADDR_W       = 5;
  localparam int QUEUE_DEPTH      = 2;
  localparam int TRAILER_BYTES_DEF = 7;
  localparam int MSG_LEN_BITS_DEF  = 20;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_BEGIN_TAG    = 2'd0;
  localparam logic [1:0] REG_TAG_LENGTH   = 2'd1;
  localparam logic [1:0] REG_MAX_BODY_LEN = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BEGIN_TAG_RST = 64'h0000_0038_3D46_4958;
  localparam logic [TAG_LEN_W-1:0]  TAG_LEN_RST   = 4'd5;
  localparam logic [BL_W-1:0]       MAX_BODY_RST  = 16'd4096;

  localparam logic [DATA_W-1:0] SOH_BYTE   = 8'h01;
  localparam logic [DATA_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [DATA_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [DATA_W-1:0] ASCII_EQ   = 8'h3D;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_NINE,
    PH_DIGITS,
    PH_BODY
  } phase_t;

  // Live configuration seen by front and back.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] begin_tag;
    logic [TAG_LEN_W-1:0]  tag_len;     // effective length, 1..TAG_BYTES
    logic [BL_W-1:0]       max_body;
  } cfg_t;

  // Classification of one received byte.
  typedef struct packed {
    logic [TAG_BYTES-1:0] tag_hit;      // byte equals tag byte k
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 is_soh;
    logic                 is_nine;
    logic                 is_eq;
  } beat_class_t;

endpackage

// ----- design/fmf_front.sv -----
// Front end: classifies each received byte against the tag and the FIX delimiters.
// Depends on fmf_pkg.
module fmf_front (
  input  logic [fmf_pkg::DATA_W-1:0] data_byte,
  input  fmf_pkg::cfg_t              cfg,
  output fmf_pkg::beat_class_t       cls
);

  always_comb begin : classify
    logic [fmf_pkg::TAG_LEN_W-1:0] sel;
    sel = '0;
    for (int k = 0; k < fmf_pkg::TAG_BYTES; k++) begin
      // tag byte k sits (len-1-k) bytes above the lowest byte
      sel = fmf_pkg::TAG_LEN_W'(cfg.tag_len - fmf_pkg::TAG_LEN_W'(1) -
                                fmf_pkg::TAG_LEN_W'(k));
      cls.tag_hit[k] = (data_byte ==
                        cfg.begin_tag[8*sel[fmf_pkg::TAG_IDX_W-1:0] +: fmf_pkg::DATA_W]);
    end
    cls.is_digit = (data_byte >= fmf_pkg::ASCII_ZERO) && (data_byte <= fmf_pkg::ASCII_NINE);
    cls.digit    = 4'(data_byte - fmf_pkg::ASCII_ZERO);
    cls.is_soh   = (data_byte == fmf_pkg::SOH_BYTE);
    cls.is_nine  = (data_byte == fmf_pkg::ASCII_NINE);
    cls.is_eq    = (data_byte == fmf_pkg::ASCII_EQ);
  end

endmodule

// ----- design/fmf_queue.sv -----
// Short queue of classified beats between front and back.
// Depends on fmf_pkg.
module fmf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fmf_pkg::beat_class_t push_data,
  output logic                 full,
  input  logic                 pop,
  output fmf_pkg::beat_class_t pop_data,
  output logic                 not_empty
);

  localparam int PTR_W = (fmf_pkg::QUEUE_DEPTH > 1) ? $clog2(fmf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(fmf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fmf_pkg::QUEUE_DEPTH - 1);

  fmf_pkg::beat_class_t entry_r [fmf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(fmf_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/fmf_back.sv -----
// Back end: framing state machine, length parse, byte counting and result register.
// Depends on fmf_pkg.
module fmf_back #(
  parameter int TRAILER_BYTES = fmf_pkg::TRAILER_BYTES_DEF,
  parameter int MSG_LEN_BITS  = fmf_pkg::MSG_LEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fmf_pkg::cfg_t                      cfg,
  input  logic                               q_valid,
  input  fmf_pkg::beat_class_t               q_data,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fmf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  localparam int TLW = fmf_pkg::TAG_LEN_W;
  localparam int DCW = fmf_pkg::DIGIT_CNT_W;
  localparam int BLW = fmf_pkg::BL_W;
  localparam int RMW = fmf_pkg::REM_W;
  localparam int PADW = fmf_pkg::OUT_TDATA_W - fmf_pkg::ML_W - fmf_pkg::BL_W;

  fmf_pkg::phase_t phase_r, phase_nxt;
  logic [TLW-1:0]          tmc_r, tmc_nxt;
  logic                    saw_nine_r, saw_nine_nxt;
  logic [DCW-1:0]          dcnt_r, dcnt_nxt;
  logic [BLW-1:0]          acc_r, acc_nxt;
  logic [RMW-1:0]          rem_r, rem_nxt;
  logic [MSG_LEN_BITS-1:0] bim_r, bim_nxt;

  logic                        out_valid_r;
  logic                        out_status_r, out_status_nxt;
  logic [fmf_pkg::ML_W-1:0]    out_ml_r, out_ml_nxt;
  logic [BLW-1:0]              out_bl_r, out_bl_nxt;

  logic                    tag_done, eq_seen, len_ok, emit;
  logic [MSG_LEN_BITS-1:0] bim_inc;
  logic [31:0]             ml_ext;

  // Take a byte unless it would emit while the previous result beat still waits.
  assign q_pop = q_valid && (!emit || !out_valid_r || out_tready);

  // Count one more message byte, holding at all ones.
  assign bim_inc = (bim_r == '1) ? bim_r : bim_r + MSG_LEN_BITS'(1);
  assign ml_ext  = 32'(bim_inc);

  // Datapath and result fields
  always_comb begin : datapath
    logic [TLW-1:0] cur;
    logic [TLW-1:0] match;
    logic [19:0]    val;
    cur            = '0;
    match          = '0;
    val            = '0;
    tmc_nxt        = tmc_r;
    saw_nine_nxt   = saw_nine_r;
    dcnt_nxt       = dcnt_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    bim_nxt        = bim_r;
    tag_done       = 1'b0;
    eq_seen        = 1'b0;
    len_ok         = 1'b0;
    emit           = 1'b0;
    out_status_nxt = fmf_pkg::STATUS_OK;
    out_ml_nxt     = ml_ext[fmf_pkg::ML_W-1:0];
    out_bl_nxt     = '0;
    case (phase_r)
      fmf_pkg::PH_HUNT: begin
        // restart a count that a shorter tag length left out of range
        cur   = (tmc_r >= cfg.tag_len) ? '0 : tmc_r;
        match = q_data.tag_hit[cur[fmf_pkg::TAG_IDX_W-1:0]] ? cur + TLW'(1)
                                                            : TLW'(q_data.tag_hit[0]);
        if (match >= cfg.tag_len) begin
          tag_done     = 1'b1;
          tmc_nxt      = '0;
          saw_nine_nxt = 1'b0;
          bim_nxt      = MSG_LEN_BITS'(cfg.tag_len);
        end else begin
          tmc_nxt = match;
        end
      end
      fmf_pkg::PH_NINE: begin
        bim_nxt = bim_inc;
        if (saw_nine_r && q_data.is_eq) begin
          eq_seen      = 1'b1;
          dcnt_nxt     = '0;
          acc_nxt      = '0;
          saw_nine_nxt = 1'b0;
        end else begin
          saw_nine_nxt = q_data.is_nine;
        end
      end
      fmf_pkg::PH_DIGITS: begin
        bim_nxt = bim_inc;
        if (q_data.is_digit) begin
          val = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 20'(q_data.digit);
          if (val > 20'(cfg.max_body)) begin
            emit           = 1'b1;
            out_status_nxt = fmf_pkg::STATUS_BAD_LEN;
          end else begin
            acc_nxt = val[BLW-1:0];
            if (dcnt_r != '1) begin
              dcnt_nxt = dcnt_r + DCW'(1);
            end
          end
        end else if (q_data.is_soh && (dcnt_r != '0)) begin
          len_ok  = 1'b1;
          rem_nxt = {1'b0, acc_r} + RMW'(TRAILER_BYTES);
          if (rem_nxt == '0) begin
            emit       = 1'b1;
            out_bl_nxt = acc_r;
          end
        end else begin
          emit           = 1'b1;
          out_status_nxt = fmf_pkg::STATUS_BAD_LEN;
        end
      end
      fmf_pkg::PH_BODY: begin
        bim_nxt = bim_inc;
        rem_nxt = (rem_r != '0) ? rem_r - RMW'(1) : rem_r;
        if (rem_r <= RMW'(1)) begin
          emit       = 1'b1;
          out_bl_nxt = acc_r;
        end
      end
      default: begin
      end
    endcase
    // drop all framing state once a result goes out
    if (emit) begin
      tmc_nxt      = '0;
      saw_nine_nxt = 1'b0;
      dcnt_nxt     = '0;
      acc_nxt      = '0;
      rem_nxt      = '0;
      bim_nxt      = '0;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      fmf_pkg::PH_HUNT: begin
        if (tag_done) phase_nxt = fmf_pkg::PH_NINE;
      end
      fmf_pkg::PH_NINE: begin
        if (eq_seen) phase_nxt = fmf_pkg::PH_DIGITS;
      end
      fmf_pkg::PH_DIGITS: begin
        if (emit) begin
          phase_nxt = fmf_pkg::PH_HUNT;
        end else if (len_ok) begin
          phase_nxt = fmf_pkg::PH_BODY;
        end
      end
      fmf_pkg::PH_BODY: begin
        if (emit) phase_nxt = fmf_pkg::PH_HUNT;
      end
      default: phase_nxt = fmf_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fmf_pkg::PH_HUNT;
      tmc_r       <= '0;
      saw_nine_r  <= 1'b0;
      dcnt_r      <= '0;
      acc_r       <= '0;
      rem_r       <= '0;
      bim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r    <= phase_nxt;
        tmc_r      <= tmc_nxt;
        saw_nine_r <= saw_nine_nxt;
        dcnt_r     <= dcnt_nxt;
        acc_r      <= acc_nxt;
        rem_r      <= rem_nxt;
        bim_r      <= bim_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_status_r <= out_status_nxt;
      out_ml_r     <= out_ml_nxt;
      out_bl_r     <= out_bl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PADW{1'b0}}, out_bl_r, out_ml_r};

endmodule

// ----- design/fix_message_framer.sv -----
// Top level of the FIX message framer: configuration registers, front, queue, back.
// Depends on fmf_pkg, fmf_front, fmf_queue and fmf_back.
//
// Usage:
//   in_*   : byte stream, one byte per beat in in_tdata.
//   out_*  : one beat per framed message or bad length field.
//            out_tdata = message_length [19:0], body_length [35:20], zero pad.
//            out_tuser = frame_status (0 complete message, 1 bad length field).
//   APB    : begin_tag at 0x00, begin_tag_length at 0x08, max_body_length at 0x10.
//            Write only while the framer is idle; writes take effect at once.
// Throughput: one byte per cycle unless a held result beat stops the back end; set
//   by its state update (tag compare, or the multiply-by-ten length accumulate).
// Result path: the byte ending the message is written into the queue; the back end
//   registers the result beat onto out_tvalid as it pops that byte from the queue.
// Reset: rst_n low clears the queue, the framing state and the output beat;
//   registers return to "8=FIX", length 5, body limit 4096; hunting resumes.
// Stall: while out_tready is low the result beat holds; the back end keeps
//   taking bytes until one would produce a second result, then the two-entry
//   queue fills and in_tready drops.
module fix_message_framer #(
  parameter int TRAILER_BYTES = fmf_pkg::TRAILER_BYTES_DEF,
  parameter int MSG_LEN_BITS  = fmf_pkg::MSG_LEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: data_byte [7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fmf_pkg::DATA_W-1:0]        in_tdata,
  // out_tdata: message_length [19:0], body_length [35:20], zeros [39:36]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fmf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: frame_status [0]
  output logic                              out_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fmf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fmf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fmf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [fmf_pkg::CFG_DATA_W-1:0] begin_tag_r;
  logic [fmf_pkg::TAG_LEN_W-1:0]  tag_len_r;
  logic [fmf_pkg::BL_W-1:0]       max_body_r;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  fmf_pkg::cfg_t        cfg;
  fmf_pkg::beat_class_t cls;
  fmf_pkg::beat_class_t q_data;
  logic                 q_full, q_valid, q_pop, push;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_tag_r <= fmf_pkg::BEGIN_TAG_RST;
      tag_len_r   <= fmf_pkg::TAG_LEN_RST;
      max_body_r  <= fmf_pkg::MAX_BODY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        fmf_pkg::REG_BEGIN_TAG:    begin_tag_r <= pwdata;
        fmf_pkg::REG_TAG_LENGTH:   tag_len_r   <= pwdata[fmf_pkg::TAG_LEN_W-1:0];
        fmf_pkg::REG_MAX_BODY_LEN: max_body_r  <= pwdata[fmf_pkg::BL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fmf_pkg::REG_BEGIN_TAG:    prdata = begin_tag_r;
      fmf_pkg::REG_TAG_LENGTH:   prdata = fmf_pkg::CFG_DATA_W'(tag_len_r);
      fmf_pkg::REG_MAX_BODY_LEN: prdata = fmf_pkg::CFG_DATA_W'(max_body_r);
      default:                   prdata = '0;
    endcase
  end

  // Clamp the tag length: zero acts as one, anything above the tag width as full.
  always_comb begin
    cfg.begin_tag = begin_tag_r;
    cfg.max_body  = max_body_r;
    if (tag_len_r == '0) begin
      cfg.tag_len = fmf_pkg::TAG_LEN_W'(1);
    end else if (tag_len_r > fmf_pkg::TAG_LEN_W'(fmf_pkg::TAG_BYTES)) begin
      cfg.tag_len = fmf_pkg::TAG_LEN_W'(fmf_pkg::TAG_BYTES);
    end else begin
      cfg.tag_len = tag_len_r;
    end
  end

  // Accept a beat whenever the queue has room.
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  fmf_front u_front (
    .data_byte (in_tdata),
    .cfg       (cfg),
    .cls       (cls)
  );

  fmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  fmf_back #(
    .TRAILER_BYTES (TRAILER_BYTES),
    .MSG_LEN_BITS  (MSG_LEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- design/fmf_checker.sv -----
// Port-level checks on the framer's result channel, bound to the top level.
// Depends on fmf_pkg and fix_message_framer_assert.svh.
`include "fix_message_framer_assert.svh"

module fmf_checker #(
  parameter int TRAILER_BYTES = fmf_pkg::TRAILER_BYTES_DEF,
  parameter int MSG_LEN_BITS  = fmf_pkg::MSG_LEN_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fmf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // shortest framing around a body: one tag byte, "9=", one digit, SOH
  localparam int MIN_OVERHEAD = 5;
  localparam int MIN_SPAN     = TRAILER_BYTES + MIN_OVERHEAD;
  localparam int PAD_LO       = fmf_pkg::ML_W + fmf_pkg::BL_W;
  // the field shows the true count only when the counter is exactly as wide:
  // a narrower one saturates low, a wider one wraps when masked
  localparam bit ML_FULL = (MSG_LEN_BITS == fmf_pkg::ML_W);

  logic [fmf_pkg::ML_W-1:0] ml_field;
  logic [fmf_pkg::BL_W-1:0] bl_field;
  logic                     out_held;
  logic                     ok_beat;
  logic                     bad_beat;

  assign ml_field = out_tdata[fmf_pkg::ML_W-1:0];
  assign bl_field = out_tdata[PAD_LO-1:fmf_pkg::ML_W];
  assign out_held = out_tvalid && !out_tready;
  assign ok_beat  = out_tvalid && (out_tuser == fmf_pkg::STATUS_OK);
  assign bad_beat = out_tvalid && (out_tuser == fmf_pkg::STATUS_BAD_LEN);

  // hold a stalled result beat
  `FMF_ASSERT_NEXT(a_out_hold, out_held, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // bad length results carry a zero body length
  `FMF_ASSERT_IMPL(a_err_zero_body, bad_beat, bl_field == '0)

  // pad bits stay zero
  `FMF_ASSERT_IMPL(a_pad_zero, out_tvalid, out_tdata[fmf_pkg::OUT_TDATA_W-1:PAD_LO] == '0)

  // a complete message covers at least its body, trailer and framing bytes
  `FMF_ASSERT_IMPL(a_len_cover, ok_beat && ML_FULL, 32'(ml_field) >= 32'(bl_field) + 32'(MIN_SPAN))

endmodule

bind fix_message_framer fmf_checker #(
  .TRAILER_BYTES (TRAILER_BYTES),
  .MSG_LEN_BITS  (MSG_LEN_BITS)
) u_fmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
